// File: design/uef_pkg.sv
// ----------------------------------------------------------------------------
// uef_pkg
// Shared types and constants of the unique entry FIFO.
// ----------------------------------------------------------------------------
package uef_pkg;

    localparam int OP_BITS    = 2;
    localparam int TASK_BITS  = 32;
    localparam int COUNT_BITS = 5;

    typedef logic [OP_BITS-1:0] t_op;

    localparam t_op OP_PUSH = 2'd0;
    localparam t_op OP_POP  = 2'd1;
    localparam t_op OP_PEEK = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FETCH,
        ST_DONE
    } t_state;

endpackage

// File: design/uef_ram.sv
// ----------------------------------------------------------------------------
// uef_ram
// Generic single-clock RAM, one write port and one read port, registered read.
// ----------------------------------------------------------------------------
module uef_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/unique_entry_fifo.sv
// ----------------------------------------------------------------------------
// unique_entry_fifo
// FIFO of task handles that refuses duplicates; entries live in one RAM.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_ready) carries one word: an op (push, pop,
// peek; code 3 acts as peek) and a task handle. Output channel (o_out_valid /
// i_out_ready) returns one word per input word: the front handle (zero when
// empty), front valid, entry count, and duplicate / full flags for a push.
// One word is processed at a time. A push reads every stored entry from the
// RAM, one read per cycle, and compares each against the handle; its result
// follows the scan of all N stored entries, N being the entry count before
// the push. A pop that leaves the queue non-empty reads the new front from the
// RAM in ST_FETCH; peek and other pops go from ST_IDLE straight to ST_DONE.
// The next word is taken once the previous result sits in the output register.
// When the receiver stalls, the result holds in the output register and the
// block stalls only if a later word's result is ready before it drains.
// Reset empties the queue at once; RAM contents are never cleared, as data
// read from slots that hold no live entry is never used.
// ----------------------------------------------------------------------------
module unique_entry_fifo #(
    parameter int QUEUE_DEPTH = 16,
    parameter int HANDLE_BITS = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  uef_pkg::t_op                   i_op,
    input  logic [uef_pkg::TASK_BITS-1:0]  i_task_req,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [uef_pkg::TASK_BITS-1:0]  o_front_task,
    output logic                           o_front_valid,
    output logic [uef_pkg::COUNT_BITS-1:0] o_count,
    output logic                           o_was_duplicate,
    output logic                           o_was_full
);

    import uef_pkg::*;

    localparam int STORE_BITS = (HANDLE_BITS < TASK_BITS) ? HANDLE_BITS : TASK_BITS;
    localparam int IDX_W      = $clog2(QUEUE_DEPTH);
    localparam int CNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

    function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] idx);
        logic [IDX_W-1:0] inc;
        inc = idx + 1'b1;
        return (idx == LAST_IDX) ? '0 : inc;
    endfunction

    t_state r_state;
    t_state n_state;

    logic [IDX_W-1:0]      r_head;
    logic [IDX_W-1:0]      r_tail;
    logic [CNT_W-1:0]      r_count;
    logic [CNT_W-1:0]      r_left;
    logic [IDX_W-1:0]      r_addr;
    logic                  r_pend;
    logic                  r_hit;
    logic                  r_dup;
    logic                  r_full;
    logic [STORE_BITS-1:0] r_req;
    logic [STORE_BITS-1:0] r_front;

    logic                  r_out_valid;
    logic [STORE_BITS-1:0] r_out_front;
    logic                  r_out_fv;
    logic [CNT_W-1:0]      r_out_count;
    logic                  r_out_dup;
    logic                  r_out_full;

    logic                  w_accept;
    logic                  w_out_free;
    logic                  w_out_load;
    logic                  w_scan_hit;
    logic                  w_found;
    logic                  w_scan_end;
    logic                  ram_we;
    logic                  ram_re;
    logic [IDX_W-1:0]      ram_raddr;
    logic [STORE_BITS-1:0] ram_rdata;

    logic [TASK_BITS+STORE_BITS-1:0] w_front_ext;
    logic [COUNT_BITS+CNT_W-1:0]     w_count_ext;

    uef_ram #(
        .WIDTH (STORE_BITS),
        .DEPTH (QUEUE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_tail),
        .i_wdata (r_req),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign w_accept   = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_scan_hit = r_pend && (ram_rdata == r_req);
    assign w_found    = r_hit || w_scan_hit;
    assign w_scan_end = (r_state == ST_SCAN) && (r_left == '0);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    unique case (i_op)
                        OP_PUSH: n_state = ST_SCAN;
                        OP_POP:  n_state = (r_count > CNT_W'(1)) ? ST_FETCH : ST_DONE;
                        default: n_state = ST_DONE;
                    endcase
                end
            end
            ST_SCAN: begin
                if (r_left == '0) begin
                    n_state = ST_DONE;
                end
            end
            ST_FETCH: n_state = ST_DONE;
            ST_DONE: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        ram_re     = 1'b0;
        ram_raddr  = r_addr;
        ram_we     = 1'b0;
        w_out_load = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                ram_raddr  = next_idx(r_head);
                ram_re     = w_accept && (i_op == OP_POP);
            end
            ST_SCAN: begin
                ram_re = (r_left != '0);
                ram_we = w_scan_end && !w_found && (r_count != FULL_CNT);
            end
            ST_FETCH: ;
            ST_DONE: w_out_load = w_out_free;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
            r_left  <= '0;
            r_pend  <= 1'b0;
            r_hit   <= 1'b0;
            r_dup   <= 1'b0;
            r_full  <= 1'b0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_left <= r_count;
                        r_pend <= 1'b0;
                        r_hit  <= 1'b0;
                        r_dup  <= 1'b0;
                        r_full <= 1'b0;
                        if (i_op == OP_POP && r_count != '0) begin
                            r_count <= r_count - 1'b1;
                            if (r_count == CNT_W'(1)) begin
                                r_head <= '0;
                                r_tail <= '0;
                            end else begin
                                r_head <= next_idx(r_head);
                            end
                        end
                    end
                end
                ST_SCAN: begin
                    r_pend <= (r_left != '0);
                    if (r_left != '0) begin
                        r_left <= r_left - 1'b1;
                    end
                    if (w_scan_hit) begin
                        r_hit <= 1'b1;
                    end
                    if (r_left == '0) begin
                        if (w_found) begin
                            r_dup <= 1'b1;
                        end else if (r_count == FULL_CNT) begin
                            r_full <= 1'b1;
                        end else begin
                            r_tail  <= next_idx(r_tail);
                            r_count <= r_count + 1'b1;
                        end
                    end
                end
                ST_FETCH: ;
                ST_DONE: ;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req  <= i_task_req[STORE_BITS-1:0];
            r_addr <= r_head;
        end else if (r_state == ST_SCAN && r_left != '0) begin
            r_addr <= next_idx(r_addr);
        end
        if (ram_we && r_count == '0) begin
            r_front <= r_req;
        end else if (r_state == ST_FETCH) begin
            r_front <= ram_rdata;
        end
        if (w_out_load) begin
            r_out_front <= (r_count != '0) ? r_front : '0;
            r_out_fv    <= (r_count != '0);
            r_out_count <= r_count;
            r_out_dup   <= r_dup;
            r_out_full  <= r_full;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign w_front_ext     = {{TASK_BITS{1'b0}}, r_out_front};
    assign w_count_ext     = {{COUNT_BITS{1'b0}}, r_out_count};
    assign o_out_valid     = r_out_valid;
    assign o_front_task    = w_front_ext[TASK_BITS-1:0];
    assign o_front_valid   = r_out_fv;
    assign o_count         = w_count_ext[COUNT_BITS-1:0];
    assign o_was_duplicate = r_out_dup;
    assign o_was_full      = r_out_full;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("entry count exceeds queue depth");

    a_empty_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_head == '0 && r_tail == '0))
        else $error("empty queue with nonzero indices");

    a_write_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |=> (r_count != '0 && !r_dup && !r_full))
        else $error("store write without a counted entry");

    a_flags_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_was_duplicate && o_was_full))
        else $error("duplicate and full flagged together");

    a_front_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_front_valid == (r_out_count != '0)))
        else $error("front valid disagrees with count");
`endif

endmodule
